### rtl/pcmr_pkg.sv
// pcmr_pkg: shared sizes, command codes, decoded op kinds and the op beat
// passed from the front end to the back end of the mailbox rings block.
// No dependencies.
`default_nettype none

package pcmr_pkg;

   // block sizing
   localparam int NUM_CORES  = 4;
   localparam int RING_DEPTH = 16;
   localparam int CODE_W     = 64;
   localparam int HB_W       = 64;
   localparam int CMD_W      = 3;
   localparam int IDX_W      = 4;

   // derived widths
   localparam int CORE_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
   localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int ADDR_W = $clog2(NUM_CORES * RING_DEPTH);

   // decoupling queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // command codes on the request channel
   typedef enum logic [CMD_W-1:0] {
      CMD_START   = 3'd0,
      CMD_STOP    = 3'd1,
      CMD_SEND    = 3'd2,
      CMD_CONSUME = 3'd3,
      CMD_HB_READ = 3'd4
   } cmd_type;

   // classified operation kinds
   typedef enum logic [2:0] {
      OP_REFUSE,
      OP_START,
      OP_STOP,
      OP_SEND,
      OP_CONSUME,
      OP_HB_READ
   } op_kind_type;

   // one decoded command beat
   typedef struct packed {
      op_kind_type        kind;
      logic [CORE_W-1:0]  core;
      logic [CODE_W-1:0]  code;
   } op_type;

   // ring pointer advance with wrap
   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(RING_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + PTR_W'(1);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

### rtl/per_core_mailbox_rings.sv
// Inter-processor mailbox with one code ring, running flag and heartbeat per
// secondary core. A front end checks and queues each request beat in a
// two-entry queue; a back end holds the response register and executes one
// queued command per cycle while rsp_stall is low, so one command is taken
// per cycle sustained, and a response is registered once its request beat
// has left the front queue and been executed by the back end. The ring
// memory has one write port and one registered read port, which bounds each
// command to a single slot access. Each ring holds RING_DEPTH-1 codes. There
// is no clearing pass after reset: ring slots are read only once written.
// Write csr_wdata (ready gate) only while no command is in flight.
// Depends on pcmr_pkg, pcmr_front and pcmr_back.
`default_nettype none

module per_core_mailbox_rings (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [pcmr_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [pcmr_pkg::IDX_W-1:0]    req_core_index,
   input  wire logic [pcmr_pkg::CODE_W-1:0]   req_code_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_accepted,
   output logic [pcmr_pkg::CODE_W-1:0]        rsp_code_out,
   output logic [pcmr_pkg::HB_W-1:0]          rsp_heartbeat_out,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic                          csr_wdata
);

   logic              gate_ff;
   logic              head_valid;
   logic              head_pop;
   pcmr_pkg::op_type  head_op;

   // ready gate register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         gate_ff <= csr_wdata;
      end
   end

   pcmr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_core_index (req_core_index),
      .req_code_in    (req_code_in),
      .head_valid     (head_valid),
      .head_op        (head_op),
      .head_pop       (head_pop)
   );

   pcmr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .gate              (gate_ff),
      .head_valid        (head_valid),
      .head_op           (head_op),
      .head_pop          (head_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_code_out      (rsp_code_out),
      .rsp_heartbeat_out (rsp_heartbeat_out)
   );

endmodule

`default_nettype wire

### rtl/pcmr_front.sv
// pcmr_front: accepts request beats, checks the core id and command code,
// and queues decoded ops for the back end. Depends on pcmr_pkg.
`default_nettype none

module pcmr_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [pcmr_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [pcmr_pkg::IDX_W-1:0]    req_core_index,
   input  wire logic [pcmr_pkg::CODE_W-1:0]   req_code_in,
   output logic                               head_valid,
   output pcmr_pkg::op_type                   head_op,
   input  wire logic                          head_pop
);

   pcmr_pkg::op_type                    dec_op;
   logic                                in_range;
   logic                                push;
   pcmr_pkg::op_type                    queue_ff [pcmr_pkg::QDEPTH];
   logic [pcmr_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [pcmr_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [pcmr_pkg::QCNT_W-1:0]         count_ff, count_in;

   // secondary cores only: 1 .. NUM_CORES-1
   assign in_range = (req_core_index != '0) &&
                     ({1'b0, req_core_index} < (pcmr_pkg::IDX_W+1)'(pcmr_pkg::NUM_CORES));

   // classify the beat
   always_comb begin
      dec_op.core = req_core_index[pcmr_pkg::CORE_W-1:0];
      dec_op.code = req_code_in;
      dec_op.kind = pcmr_pkg::OP_REFUSE;
      if (in_range) begin
         unique case (req_cmd)
            pcmr_pkg::CMD_START:   dec_op.kind = pcmr_pkg::OP_START;
            pcmr_pkg::CMD_STOP:    dec_op.kind = pcmr_pkg::OP_STOP;
            pcmr_pkg::CMD_SEND:    dec_op.kind = pcmr_pkg::OP_SEND;
            pcmr_pkg::CMD_CONSUME: dec_op.kind = pcmr_pkg::OP_CONSUME;
            pcmr_pkg::CMD_HB_READ: dec_op.kind = pcmr_pkg::OP_HB_READ;
            default:               dec_op.kind = pcmr_pkg::OP_REFUSE;
         endcase
      end
   end

   // queue control
   assign req_stall  = (count_ff == pcmr_pkg::QCNT_W'(pcmr_pkg::QDEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign head_op    = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == pcmr_pkg::QPTR_W'(pcmr_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + pcmr_pkg::QPTR_W'(1);
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == pcmr_pkg::QPTR_W'(pcmr_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + pcmr_pkg::QPTR_W'(1);
      end
      if (push && !head_pop) begin
         count_in = count_ff + pcmr_pkg::QCNT_W'(1);
      end else if (!push && head_pop) begin
         count_in = count_ff - pcmr_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= dec_op;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pcmr_pkg::QCNT_W'(pcmr_pkg::QDEPTH))
      else $error("front queue count overflow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("pop from empty front queue");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !head_pop) |=> (count_ff == $past(count_ff) + pcmr_pkg::QCNT_W'(1)))
      else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

### rtl/pcmr_back.sv
// pcmr_back: executes decoded ops against the per-core pointers, flags,
// heartbeats and ring memory, and holds the result register.
// Depends on pcmr_pkg.
`default_nettype none

module pcmr_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          gate,
   input  wire logic                          head_valid,
   input  wire pcmr_pkg::op_type              head_op,
   output logic                               head_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_accepted,
   output logic [pcmr_pkg::CODE_W-1:0]        rsp_code_out,
   output logic [pcmr_pkg::HB_W-1:0]          rsp_heartbeat_out
);

   localparam int NC = pcmr_pkg::NUM_CORES;

   logic [pcmr_pkg::PTR_W-1:0]   wp_ff [NC];
   logic [pcmr_pkg::PTR_W-1:0]   rp_ff [NC];
   logic                         run_ff [NC];
   logic [pcmr_pkg::HB_W-1:0]    hb_ff [NC];
   logic [pcmr_pkg::CODE_W-1:0]  ring_mem [NC * pcmr_pkg::RING_DEPTH];

   logic [pcmr_pkg::CORE_W-1:0]  c;
   logic [pcmr_pkg::PTR_W-1:0]   w, r;
   logic [pcmr_pkg::HB_W-1:0]    hb_cur;
   logic                         run_cur;
   logic [pcmr_pkg::PTR_W-1:0]   wp_in, rp_in;
   logic                         run_in;
   logic [pcmr_pkg::HB_W-1:0]    hb_in;
   logic                         wp_we, rp_we, run_we, hb_we, mem_we, mem_re;
   logic [pcmr_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
   logic                         acc_in;
   logic [pcmr_pkg::HB_W-1:0]    hout_in;

   logic                         rsp_valid_ff;
   logic                         acc_ff;
   logic                         popped_ff;
   logic [pcmr_pkg::HB_W-1:0]    hout_ff;
   logic [pcmr_pkg::CODE_W-1:0]  mem_q_ff;

   // current core state
   assign c       = head_op.core;
   assign w       = wp_ff[c];
   assign r       = rp_ff[c];
   assign hb_cur  = hb_ff[c];
   assign run_cur = run_ff[c];
   assign wr_addr = pcmr_pkg::ADDR_W'(int'(c) * pcmr_pkg::RING_DEPTH + int'(w));
   assign rd_addr = pcmr_pkg::ADDR_W'(int'(c) * pcmr_pkg::RING_DEPTH + int'(r));

   // take the next op whenever the result register frees up
   assign head_pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   // execute one op
   always_comb begin
      wp_in   = w;
      rp_in   = r;
      run_in  = run_cur;
      hb_in   = hb_cur;
      wp_we   = 1'b0;
      rp_we   = 1'b0;
      run_we  = 1'b0;
      hb_we   = 1'b0;
      mem_we  = 1'b0;
      mem_re  = 1'b0;
      acc_in  = 1'b0;
      hout_in = '0;
      unique case (head_op.kind)
         pcmr_pkg::OP_START: begin
            wp_in  = '0;
            rp_in  = '0;
            hb_in  = '0;
            run_in = 1'b1;
            wp_we  = 1'b1;
            rp_we  = 1'b1;
            hb_we  = 1'b1;
            run_we = 1'b1;
            acc_in = 1'b1;
         end
         pcmr_pkg::OP_STOP: begin
            run_in = 1'b0;
            run_we = 1'b1;
            acc_in = 1'b1;
         end
         pcmr_pkg::OP_SEND: begin
            if (pcmr_pkg::ring_next(w) != r) begin
               wp_in  = pcmr_pkg::ring_next(w);
               wp_we  = 1'b1;
               mem_we = 1'b1;
               acc_in = 1'b1;
            end
         end
         pcmr_pkg::OP_CONSUME: begin
            if (gate && run_cur && (r != w)) begin
               rp_in   = pcmr_pkg::ring_next(r);
               rp_we   = 1'b1;
               hb_in   = hb_cur + pcmr_pkg::HB_W'(1);
               hb_we   = 1'b1;
               mem_re  = 1'b1;
               hout_in = hb_cur + pcmr_pkg::HB_W'(1);
               acc_in  = 1'b1;
            end
         end
         pcmr_pkg::OP_HB_READ: begin
            hout_in = hb_cur;
            acc_in  = 1'b1;
         end
         default: begin
            acc_in = 1'b0;
         end
      endcase
   end

   // per-core control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NC; i++) begin
            wp_ff[i]  <= '0;
            rp_ff[i]  <= '0;
            run_ff[i] <= 1'b0;
            hb_ff[i]  <= '0;
         end
      end else if (head_pop) begin
         if (wp_we) begin
            wp_ff[c] <= wp_in;
         end
         if (rp_we) begin
            rp_ff[c] <= rp_in;
         end
         if (run_we) begin
            run_ff[c] <= run_in;
         end
         if (hb_we) begin
            hb_ff[c] <= hb_in;
         end
      end
   end

   // ring memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (head_pop && mem_we) begin
         ring_mem[wr_addr] <= head_op.code;
      end
      if (head_pop && mem_re) begin
         mem_q_ff <= ring_mem[rd_addr];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (head_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         acc_ff    <= acc_in;
         popped_ff <= mem_re;
         hout_ff   <= hout_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = acc_ff;
   assign rsp_code_out      = popped_ff ? mem_q_ff : '0;
   assign rsp_heartbeat_out = hout_ff;

`ifndef SYNTHESIS
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> (rsp_code_out == '0 && rsp_heartbeat_out == '0))
      else $error("refused beat carries data");
   a_pop_accepted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && popped_ff) |-> acc_ff)
      else $error("ring pop without accept");
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (head_pop && head_op.kind == pcmr_pkg::OP_START) |=> run_ff[$past(c)])
      else $error("start did not set running");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_heartbeat_out)
                                    && $stable(rsp_code_out)))
      else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
